### hdl/spi_psram_frame_builder_assert.svh
// Assertion macros for the SPI PSRAM frame builder.
`ifndef SPI_PSRAM_FRAME_BUILDER_ASSERT_SVH
`define SPI_PSRAM_FRAME_BUILDER_ASSERT_SVH

`ifndef SYNTHESIS

`define SPF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`define SPF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SPF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)

`define SPF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### hdl/spf_pkg.sv
// Types, constants and codes shared by the SPI PSRAM frame builder.
`timescale 1ns / 1ps

package spf_pkg;

    localparam int ADDR_BITS   = 24;
    localparam int CHUNK_BITS  = 5;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int SEQ_W       = 3;

    localparam logic [7:0] OP_WRITE        = 8'h02;
    localparam logic [7:0] OP_FAST_READ    = 8'h0B;
    localparam logic [7:0] OP_READ_ID      = 8'h9F;
    localparam logic [7:0] OP_RESET_ENABLE = 8'h66;
    localparam logic [7:0] OP_RESET        = 8'h99;
    localparam logic [7:0] FILL_BYTE       = 8'hFF;
    localparam logic [7:0] ZERO_BYTE       = 8'h00;

    localparam logic [CHUNK_BITS-1:0] CHUNK_AT_RESET = CHUNK_BITS'(20);

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_RESET = 2'd2,
        ACT_ID    = 2'd3
    } spf_action_t;

    typedef enum logic [1:0] {
        ROLE_NONE = 2'd0,
        ROLE_DATA = 2'd1,
        ROLE_MFR  = 2'd2,
        ROLE_KGD  = 2'd3
    } spf_role_t;

    typedef struct packed {
        logic [1:0]           action;
        logic [ADDR_BITS-1:0] start_address;
        logic [7:0]           write_byte;
        logic                 first_of_transfer;
        logic                 last_of_transfer;
    } spf_in_item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_end;
        logic [1:0] rx_role;
        logic       last_result;
    } spf_out_item_t;

    typedef struct packed {
        spf_action_t          action;
        logic                 hdr;
        logic [ADDR_BITS-1:0] addr;
        logic [7:0]           data;
        logic                 close;
    } spf_desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } spf_qstat_t;

endpackage

### hdl/spi_psram_frame_builder.sv
// Top level of the SPI PSRAM frame builder.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------------
//  item      | item_valid / item_stall | spf_in_item_t  (transfer requests)
//  spi       | spi_valid  / spi_stall  | spf_out_item_t (bytes for MOSI)
//  cfg       | cfg_valid  / cfg_ready  | cfg_data       (chunk_bytes)
//
// One item is taken per cycle while the four-entry descriptor queue has room.
// The byte sequencer emits one byte per cycle unless spi stalls; an item
// is 1 to 6 bytes: 1 for a data byte inside a frame, 5 or 6 with a header.
// Reset clears the frame state, the queue and the output valid; chunk_bytes
// returns to 20. A stall on spi holds the output register and fills the queue.
`timescale 1ns / 1ps

module spi_psram_frame_builder (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  spf_pkg::spf_in_item_t  item,
    output logic                   spi_valid,
    input  logic                   spi_stall,
    output spf_pkg::spf_out_item_t spi,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [4:0]             cfg_data
);
    import spf_pkg::*;

    spf_qstat_t qstat;
    spf_desc_t  push_desc;
    spf_desc_t  head;
    logic       push;
    logic       pop;

    spf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .qstat      (qstat),
        .push       (push),
        .push_desc  (push_desc)
    );

    spf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    spf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .spi_valid (spi_valid),
        .spi_stall (spi_stall),
        .spi       (spi)
    );

endmodule

### hdl/spf_front.sv
// Front end: accepts items, tracks frame state and classifies each item.
`timescale 1ns / 1ps
`include "spi_psram_frame_builder_assert.svh"

module spf_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  spf_pkg::spf_in_item_t   item,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [4:0]              cfg_data,
    input  spf_pkg::spf_qstat_t     qstat,
    output logic                    push,
    output spf_pkg::spf_desc_t      push_desc
);
    import spf_pkg::*;

    logic [CHUNK_BITS-1:0] chunk_reg;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic [ADDR_BITS-1:0]  addr_next;
    logic [CHUNK_BITS-1:0] bytes_reg;
    logic [CHUNK_BITS-1:0] bytes_next;
    logic                  open_reg;
    logic                  open_next;

    logic [ADDR_BITS-1:0]  addr_eff;
    logic                  open_eff;
    logic [CHUNK_BITS-1:0] cnt_eff;
    logic [CHUNK_BITS-1:0] cnt_new;
    logic [CHUNK_BITS-1:0] limit;
    logic                  close;
    logic                  is_data;

    assign cfg_ready  = 1'b1;
    assign item_stall = qstat.full;
    assign push       = item_valid && !qstat.full;

    always_comb
    begin
        is_data  = (item.action == ACT_WRITE) || (item.action == ACT_READ);
        addr_eff = item.first_of_transfer ? item.start_address : addr_reg;
        open_eff = item.first_of_transfer ? 1'b0 : open_reg;
        cnt_eff  = open_eff ? bytes_reg : '0;
        cnt_new  = cnt_eff + CHUNK_BITS'(1);
        limit    = (chunk_reg == '0) ? CHUNK_BITS'(1) : chunk_reg;
        close    = item.last_of_transfer || (cnt_new >= limit);

        push_desc.action = spf_action_t'(item.action);
        push_desc.hdr    = !open_eff;
        push_desc.addr   = addr_eff;
        push_desc.data   = item.write_byte;
        push_desc.close  = close;

        addr_next  = addr_reg;
        bytes_next = bytes_reg;
        open_next  = open_reg;
        if (push)
        begin
            if (is_data)
            begin
                addr_next  = addr_eff + ADDR_BITS'(1);
                open_next  = !close;
                bytes_next = close ? '0 : cnt_new;
            end
            else
            begin
                open_next  = 1'b0;
                bytes_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg <= CHUNK_AT_RESET;
            addr_reg  <= '0;
            bytes_reg <= '0;
            open_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                chunk_reg <= cfg_data;
            end
            addr_reg  <= addr_next;
            bytes_reg <= bytes_next;
            open_reg  <= open_next;
        end
    end

    `SPF_ASSERT_IMP(a_closed_count_zero, clk, rst_n, !open_reg, bytes_reg == '0, "count set while no frame is open")
    `SPF_ASSERT_IMP(a_open_count_room, clk, rst_n, open_reg, bytes_reg != '1, "open frame holds a full count")

endmodule

### hdl/spf_queue.sv
// Short descriptor queue between the front end and the byte sequencer.
`timescale 1ns / 1ps
`include "spi_psram_frame_builder_assert.svh"

module spf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  spf_pkg::spf_desc_t  push_desc,
    input  logic                pop,
    output spf_pkg::spf_desc_t  head,
    output spf_pkg::spf_qstat_t qstat
);
    import spf_pkg::*;

    spf_desc_t          slot_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_reg;
    logic [QPTR_W-1:0]  rd_reg;
    logic [QCNT_W-1:0]  cnt_reg;
    logic [QCNT_W-1:0]  cnt_next;

    assign head        = slot_reg[rd_reg];
    assign qstat.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign qstat.empty = (cnt_reg == '0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    `SPF_ASSERT_IMP(a_no_push_full, clk, rst_n, push, !qstat.full, "push into a full queue")
    `SPF_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, !qstat.empty, "pop from an empty queue")

endmodule

### hdl/spf_back.sv
// Back end: expands each descriptor into SPI bytes through an output register.
`timescale 1ns / 1ps
`include "spi_psram_frame_builder_assert.svh"

module spf_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  spf_pkg::spf_desc_t    head,
    input  spf_pkg::spf_qstat_t   qstat,
    output logic                  pop,
    output logic                  spi_valid,
    input  logic                  spi_stall,
    output spf_pkg::spf_out_item_t spi
);
    import spf_pkg::*;

    logic [SEQ_W-1:0] idx_reg;
    logic [SEQ_W-1:0] idx_next;
    logic             valid_reg;
    logic             valid_next;
    spf_out_item_t    out_reg;
    spf_out_item_t    cur;
    logic [SEQ_W-1:0] data_idx;
    logic [SEQ_W-1:0] last_idx;
    logic             is_read;
    logic             load;
    logic             have;

    assign spi_valid = valid_reg;
    assign spi       = out_reg;

    always_comb
    begin
        is_read  = (head.action == ACT_READ);
        data_idx = head.hdr ? (is_read ? SEQ_W'(5) : SEQ_W'(4)) : '0;
        case (head.action)
            ACT_RESET: last_idx = SEQ_W'(1);
            ACT_ID:    last_idx = SEQ_W'(5);
            default:   last_idx = data_idx;
        endcase

        cur.tx_byte     = FILL_BYTE;
        cur.frame_end   = 1'b0;
        cur.rx_role     = ROLE_NONE;
        cur.last_result = (idx_reg == last_idx);
        case (head.action)
            ACT_RESET:
            begin
                cur.tx_byte   = (idx_reg == '0) ? OP_RESET_ENABLE : OP_RESET;
                cur.frame_end = 1'b1;
            end
            ACT_ID:
            begin
                case (idx_reg)
                    SEQ_W'(0): cur.tx_byte = OP_READ_ID;
                    SEQ_W'(4): cur.rx_role = ROLE_MFR;
                    SEQ_W'(5):
                    begin
                        cur.rx_role   = ROLE_KGD;
                        cur.frame_end = 1'b1;
                    end
                    default:   cur.tx_byte = ZERO_BYTE;
                endcase
            end
            default:
            begin
                if (idx_reg == data_idx)
                begin
                    cur.tx_byte   = is_read ? FILL_BYTE : head.data;
                    cur.frame_end = head.close;
                    cur.rx_role   = is_read ? ROLE_DATA : ROLE_NONE;
                end
                else
                begin
                    case (idx_reg)
                        SEQ_W'(0): cur.tx_byte = is_read ? OP_FAST_READ : OP_WRITE;
                        SEQ_W'(1): cur.tx_byte = head.addr[16 +: 8];
                        SEQ_W'(2): cur.tx_byte = head.addr[8 +: 8];
                        SEQ_W'(3): cur.tx_byte = head.addr[0 +: 8];
                        default:   cur.tx_byte = FILL_BYTE;
                    endcase
                end
            end
        endcase

        have       = !qstat.empty;
        load       = !valid_reg || !spi_stall;
        pop        = load && have && cur.last_result;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = have;
            if (have)
            begin
                idx_next = cur.last_result ? '0 : idx_reg + SEQ_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && have)
        begin
            out_reg <= cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    `SPF_ASSERT_IMP(a_idx_in_range, clk, rst_n, !qstat.empty, idx_reg <= last_idx, "byte index beyond item length")
    `SPF_ASSERT_NXT(a_pop_restarts, clk, rst_n, pop, idx_reg == '0, "byte index not cleared after pop")

endmodule

### tb/sv/tb_spi_psram_frame_builder.sv
// Testbench for the SPI PSRAM frame builder: directed and random items checked against a predictor.
`timescale 1ns / 1ps

module tb_spi_psram_frame_builder;

    import spf_pkg::*;

    localparam int ITEM_TARGET = 250;
    localparam int CYCLE_LIMIT = 500000;
    localparam int GAP_MAX     = 13;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   item_valid = 1'b0;
    logic                   item_stall;
    spf_in_item_t           item = '0;
    logic                   spi_valid;
    logic                   spi_stall = 1'b0;
    spf_out_item_t          spi;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CHUNK_BITS-1:0]  cfg_data = '0;

    logic [CHUNK_BITS-1:0]  psram_chunk_limit = CHUNK_AT_RESET;
    logic [ADDR_BITS-1:0]   psram_next_addr = '0;
    logic [CHUNK_BITS-1:0]  psram_chunk_fill = '0;
    logic                   psram_frame_open = 1'b0;

    spf_out_item_t          mosi_expected[$];
    spf_out_item_t          item_bytes[$];

    int tx_gap_max = GAP_MAX;
    int rx_gap_max = GAP_MAX;
    int spi_hold_cycles = 0;
    int items_sent = 0;
    int bytes_checked = 0;
    int chunk_writes = 0;
    int fail_count = 0;
    int cycle_count = 0;

    spi_psram_frame_builder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .spi_valid  (spi_valid),
        .spi_stall  (spi_stall),
        .spi        (spi),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int draw_gap(int max_gap);
        return (max_gap == 0) ? 0 : int'($urandom_range(max_gap, 0));
    endfunction

    function automatic void add_byte(logic [7:0] value, logic fend, spf_role_t role);
        spf_out_item_t r;
        r.tx_byte     = value;
        r.frame_end   = fend;
        r.rx_role     = role;
        r.last_result = 1'b0;
        item_bytes.push_back(r);
    endfunction

    function automatic void predict_mosi_bytes(spf_in_item_t it);
        logic                  is_read;
        logic                  close;
        logic [CHUNK_BITS-1:0] limit;
        spf_out_item_t         r;
        item_bytes.delete();
        case (spf_action_t'(it.action))
            ACT_RESET:
            begin
                psram_frame_open = 1'b0;
                psram_chunk_fill = '0;
                add_byte(OP_RESET_ENABLE, 1'b1, ROLE_NONE);
                add_byte(OP_RESET, 1'b1, ROLE_NONE);
            end
            ACT_ID:
            begin
                psram_frame_open = 1'b0;
                psram_chunk_fill = '0;
                add_byte(OP_READ_ID, 1'b0, ROLE_NONE);
                add_byte(ZERO_BYTE, 1'b0, ROLE_NONE);
                add_byte(ZERO_BYTE, 1'b0, ROLE_NONE);
                add_byte(ZERO_BYTE, 1'b0, ROLE_NONE);
                add_byte(FILL_BYTE, 1'b0, ROLE_MFR);
                add_byte(FILL_BYTE, 1'b1, ROLE_KGD);
            end
            default:
            begin
                is_read = (it.action == ACT_READ);
                limit = (psram_chunk_limit == '0) ? CHUNK_BITS'(1) : psram_chunk_limit;
                if (it.first_of_transfer)
                begin
                    psram_next_addr  = it.start_address;
                    psram_frame_open = 1'b0;
                    psram_chunk_fill = '0;
                end
                if (!psram_frame_open)
                begin
                    add_byte(is_read ? OP_FAST_READ : OP_WRITE, 1'b0, ROLE_NONE);
                    add_byte(psram_next_addr[23:16], 1'b0, ROLE_NONE);
                    add_byte(psram_next_addr[15:8], 1'b0, ROLE_NONE);
                    add_byte(psram_next_addr[7:0], 1'b0, ROLE_NONE);
                    if (is_read)
                        add_byte(FILL_BYTE, 1'b0, ROLE_NONE);
                    psram_frame_open = 1'b1;
                    psram_chunk_fill = '0;
                end
                psram_chunk_fill = psram_chunk_fill + 1'b1;
                psram_next_addr  = psram_next_addr + 1'b1;
                close = it.last_of_transfer || (psram_chunk_fill >= limit);
                add_byte(is_read ? FILL_BYTE : it.write_byte, close,
                         is_read ? ROLE_DATA : ROLE_NONE);
                if (close)
                begin
                    psram_frame_open = 1'b0;
                    psram_chunk_fill = '0;
                end
            end
        endcase
        r = item_bytes.pop_back();
        r.last_result = 1'b1;
        item_bytes.push_back(r);
        foreach (item_bytes[i])
            mosi_expected.push_back(item_bytes[i]);
    endfunction

    function automatic spf_in_item_t make_item(spf_action_t act, logic [ADDR_BITS-1:0] addr,
                                               logic [7:0] data, logic first, logic last);
        spf_in_item_t it;
        it.action            = act;
        it.start_address     = addr;
        it.write_byte        = data;
        it.first_of_transfer = first;
        it.last_of_transfer  = last;
        return it;
    endfunction

    function automatic logic [ADDR_BITS-1:0] draw_address();
        if ($urandom_range(3, 0) == 0)
            return {ADDR_BITS{1'b1}} - ADDR_BITS'($urandom_range(8, 0));
        return ADDR_BITS'($urandom);
    endfunction

    function automatic int draw_length();
        if ($urandom_range(7, 0) == 0)
            return $urandom_range(40, 9);
        return $urandom_range(8, 1);
    endfunction

    task automatic send_item(spf_in_item_t it);
        int gap;
        gap = draw_gap(tx_gap_max);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall !== 1'b0)
            @(posedge clk);
        predict_mosi_bytes(it);
        items_sent++;
    endtask

    task automatic send_transfer(spf_action_t act, int len, logic [ADDR_BITS-1:0] addr,
                                 bit broken);
        spf_action_t it_act;
        logic        first;
        logic        last;
        for (int i = 0; i < len; i++)
        begin
            it_act = act;
            first  = (i == 0);
            last   = (i == len - 1);
            if (broken)
            begin
                if ($urandom_range(3, 0) == 0)
                    it_act = (act == ACT_WRITE) ? ACT_READ : ACT_WRITE;
                if ($urandom_range(3, 0) == 0)
                    first = ~first;
                if ($urandom_range(3, 0) == 0)
                    last = ~last;
            end
            send_item(make_item(it_act, first ? addr : ADDR_BITS'($urandom),
                                8'($urandom), first, last));
        end
    endtask

    task automatic wait_for_drain();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (mosi_expected.size() != 0);
    endtask

    task automatic write_chunk_bytes(logic [CHUNK_BITS-1:0] value);
        wait_for_drain();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        psram_chunk_limit = value;
        chunk_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_idle_mode();
        tx_gap_max = $urandom_range(1, 0) ? GAP_MAX : 0;
        rx_gap_max = $urandom_range(1, 0) ? GAP_MAX : 0;
    endtask

    // Reset chunk size, header from address zero, full chunk closes the frame.
    task automatic test_reset_state();
        for (int i = 0; i < 21; i++)
            send_item(make_item(ACT_WRITE, ADDR_BITS'($urandom), 8'($urandom), 1'b0, i == 20));
    endtask

    task automatic test_directed_cases();
        send_item(make_item(ACT_WRITE, 24'hFFFFFE, 8'h00, 1'b1, 1'b0));
        send_item(make_item(ACT_WRITE, 24'h000000, 8'hFF, 1'b0, 1'b0));
        send_item(make_item(ACT_WRITE, 24'hFFFFFF, 8'hA5, 1'b0, 1'b1));
        send_item(make_item(ACT_WRITE, 24'h000000, 8'h5A, 1'b0, 1'b1));
        send_item(make_item(ACT_READ, 24'hFFFFFF, 8'hFF, 1'b1, 1'b1));
        send_item(make_item(ACT_READ, 24'h555555, 8'h00, 1'b0, 1'b0));
        send_item(make_item(ACT_WRITE, 24'hAAAAAA, 8'hC3, 1'b0, 1'b0));
        send_item(make_item(ACT_READ, 24'h000000, 8'h3C, 1'b0, 1'b1));
        send_item(make_item(ACT_WRITE, 24'h123456, 8'h11, 1'b1, 1'b0));
        send_item(make_item(ACT_WRITE, 24'hABCDEF, 8'h22, 1'b1, 1'b0));
        send_item(make_item(ACT_RESET, 24'hFFFFFF, 8'hFF, 1'b1, 1'b1));
        send_item(make_item(ACT_WRITE, 24'h000000, 8'h33, 1'b0, 1'b1));
        send_item(make_item(ACT_ID, 24'h000000, 8'h00, 1'b0, 1'b0));
        send_item(make_item(ACT_READ, 24'h800000, 8'h00, 1'b1, 1'b0));
        send_item(make_item(ACT_ID, 24'hFFFFFF, 8'hFF, 1'b1, 1'b1));
        send_item(make_item(ACT_READ, 24'h7FFFFF, 8'h80, 1'b0, 1'b1));
        send_item(make_item(ACT_RESET, 24'h000000, 8'h00, 1'b0, 1'b0));
        send_item(make_item(ACT_WRITE, 24'h00FF00, 8'h7F, 1'b1, 1'b1));
    endtask

    task automatic test_chunk_extremes();
        write_chunk_bytes(CHUNK_BITS'(0));
        send_transfer(ACT_WRITE, 3, draw_address(), 1'b0);
        send_transfer(ACT_READ, 2, draw_address(), 1'b0);
        write_chunk_bytes(CHUNK_BITS'(1));
        send_transfer(ACT_READ, 3, draw_address(), 1'b0);
        send_transfer(ACT_WRITE, 2, draw_address(), 1'b0);
        write_chunk_bytes(CHUNK_BITS'(31));
        send_transfer(ACT_WRITE, 33, 24'hFFFFF0, 1'b0);
        write_chunk_bytes(CHUNK_BITS'($urandom_range(6, 2)));
        send_transfer(ACT_READ, 8, draw_address(), 1'b0);
    endtask

    task automatic test_backpressure();
        tx_gap_max = 0;
        rx_gap_max = 0;
        spi_hold_cycles = 160;
        send_transfer(ACT_WRITE, 12, draw_address(), 1'b0);
        send_transfer(ACT_READ, 12, draw_address(), 1'b0);
        wait_for_drain();
        tx_gap_max = GAP_MAX;
        rx_gap_max = GAP_MAX;
        send_transfer(ACT_READ, 4, draw_address(), 1'b0);
    endtask

    task automatic test_random_traffic();
        int          pick;
        spf_action_t act;
        while (items_sent < ITEM_TARGET)
        begin
            pick_idle_mode();
            pick = $urandom_range(19, 0);
            act  = $urandom_range(1, 0) ? ACT_READ : ACT_WRITE;
            if (pick < 13)
                send_transfer(act, draw_length(), draw_address(), 1'b0);
            else if (pick < 16)
                send_transfer(act, draw_length(), draw_address(), 1'b1);
            else if (pick < 18)
                send_item(make_item(spf_action_t'($urandom_range(3, 0)), draw_address(),
                                    8'($urandom), 1'($urandom), 1'($urandom)));
            else if (pick == 18)
                write_chunk_bytes(CHUNK_BITS'($urandom_range(31, 0)));
            else
                wait_for_drain();
        end
    endtask

    task automatic finish_run();
        wait_for_drain();
        repeat (20) @(posedge clk);
        $display("run covered %0d items, %0d MOSI bytes checked, %0d chunk size writes",
                 items_sent, bytes_checked, chunk_writes);
        $display("  incl. reset and ID frames, address wrap, chunk sizes 0, 1, 20 and 31");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_directed_cases();
        test_chunk_extremes();
        test_backpressure();
        test_random_traffic();
        finish_run();
    end

    initial
    begin : mosi_receiver
        int wait_cycles;
        forever
        begin
            if (spi_hold_cycles > 0)
            begin
                wait_cycles = spi_hold_cycles;
                spi_hold_cycles = 0;
            end
            else
                wait_cycles = draw_gap(rx_gap_max);
            if (wait_cycles > 0)
            begin
                spi_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            spi_stall <= 1'b0;
            @(posedge clk);
            while (spi_valid !== 1'b1)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_mosi
        spf_out_item_t want;
        if (rst_n && spi_valid === 1'b1 && spi_stall == 1'b0)
        begin
            if (mosi_expected.size() == 0)
            begin
                $error("unexpected MOSI byte: tx_byte 0x%02h", spi.tx_byte);
                fail_count++;
            end
            else
            begin
                want = mosi_expected.pop_front();
                bytes_checked++;
                if (spi.tx_byte !== want.tx_byte)
                begin
                    $error("tx_byte: expected 0x%02h, got 0x%02h", want.tx_byte, spi.tx_byte);
                    fail_count++;
                end
                if (spi.frame_end !== want.frame_end)
                begin
                    $error("frame_end: expected %0b, got %0b", want.frame_end, spi.frame_end);
                    fail_count++;
                end
                if (spi.rx_role !== want.rx_role)
                begin
                    $error("rx_role: expected %0d, got %0d", want.rx_role, spi.rx_role);
                    fail_count++;
                end
                if (spi.last_result !== want.last_result)
                begin
                    $error("last_result: expected %0b, got %0b",
                           want.last_result, spi.last_result);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d bytes still expected",
                 cycle_count, mosi_expected.size());
        $display("tb: failure");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/spf_pkg.sv
hdl/spf_front.sv
hdl/spf_queue.sv
hdl/spf_back.sv
hdl/spi_psram_frame_builder.sv
tb/sv/tb_spi_psram_frame_builder.sv
